FILE: src/coordinate_deque_with_search_defines.svh
// Assertion macros shared by the coordinate deque RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef COORDINATE_DEQUE_WITH_SEARCH_DEFINES_SVH
`define COORDINATE_DEQUE_WITH_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cdq_pkg.sv
// Package for the coordinate deque: default parameters, field widths, command,
// status and state codes, and the result structure. No dependencies.
`default_nettype none

package cdq_pkg;

   localparam int DEPTH_DEF      = 256;
   localparam int COORD_BITS_DEF = 8;

   localparam int CMD_W      = 3;
   localparam int COORD_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 8;
   localparam int LEN_W      = 9;
   localparam int REQ_DATA_W = 2 * COORD_W;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK   = 3'd0,
      CMD_PUSH_FRONT  = 3'd1,
      CMD_POP_FRONT   = 3'd2,
      CMD_POP_BACK    = 3'd3,
      CMD_SEARCH      = 3'd4,
      CMD_SEARCH_SKIP = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_RESULT = 2'd2
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0] length;
      logic [POS_W-1:0] position;
      logic             found;
      status_type       status;
   } res_type;

endpackage

`default_nettype wire

FILE: src/cdq_ring_ram.sv
// Coordinate store of the deque: one write port and one read port with
// registered read data. No dependencies.
`default_nettype none

module cdq_ring_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/cdq_ring_alu.sv
// Shared ring address unit: adds an offset to the head index modulo DEPTH.
// Used for every push, pop and search address. No dependencies.
`default_nettype none

module cdq_ring_alu #(
   parameter int DEPTH = 256
) (
   input  wire logic [$clog2(DEPTH)-1:0]   base,
   input  wire logic [$clog2(DEPTH+1)-1:0] offset,
   output logic      [$clog2(DEPTH)-1:0]   addr
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   always_comb begin
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         wrapped = sum - SUM_W'(DEPTH);
      end else begin
         wrapped = sum;
      end
      addr = wrapped[IDX_W-1:0];
   end

endmodule

`default_nettype wire

FILE: src/cdq_seq.sv
// Sequencer of the coordinate deque: head and count registers, push and pop
// handling, and the one-entry-per-cycle search loop. Uses cdq_pkg, cdq_ring_alu
// and the assertion macros header.
`default_nettype none
`include "coordinate_deque_with_search_defines.svh"

module cdq_seq #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
   parameter int COORD_BITS = cdq_pkg::COORD_BITS_DEF,
   parameter int STORE_W    = (COORD_BITS < cdq_pkg::COORD_W) ? COORD_BITS : cdq_pkg::COORD_W
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [cdq_pkg::CMD_W-1:0]    cmd_bits,
   input  wire logic [cdq_pkg::COORD_W-1:0]  coord_x,
   input  wire logic [cdq_pkg::COORD_W-1:0]  coord_y,
   output logic                              res_valid,
   input  wire logic                         res_ready,
   output cdq_pkg::res_type                  res,
   output logic                              mem_wr_en,
   output logic      [$clog2(DEPTH)-1:0]     mem_wr_addr,
   output logic      [2*STORE_W-1:0]         mem_wr_data,
   output logic                              mem_rd_en,
   output logic      [$clog2(DEPTH)-1:0]     mem_rd_addr,
   input  wire logic [2*STORE_W-1:0]         mem_rd_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WIDE_W = CNT_W + cdq_pkg::LEN_W;

   cdq_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STORE_W-1:0]  key_x_ff, key_x_in;
   logic [STORE_W-1:0]  key_y_ff, key_y_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]    cmp_pos_ff, cmp_pos_in;
   cdq_pkg::status_type res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;
   logic [CNT_W-1:0]    res_pos_ff, res_pos_in;

   cdq_pkg::cmd_type    cmd;
   logic [CNT_W-1:0]    ring_off;
   logic [IDX_W-1:0]    ring_addr;
   logic                full;
   logic                empty;
   logic                match;
   logic [WIDE_W-1:0]   pos_wide;
   logic [WIDE_W-1:0]   len_wide;

   cdq_ring_alu #(
      .DEPTH (DEPTH)
   ) u_ring_alu (
      .base   (head_ff),
      .offset (ring_off),
      .addr   (ring_addr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cdq_pkg::ST_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_x_ff      <= key_x_in;
      key_y_ff      <= key_y_in;
      scan_ff       <= scan_in;
      cmp_pos_ff    <= cmp_pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_pos_ff    <= res_pos_in;
   end

   always_comb begin
      cmd   = cdq_pkg::cmd_type'(cmd_bits);
      full  = (count_ff == CNT_W'(DEPTH));
      empty = (count_ff == '0);
      match = cmp_vld_ff && (mem_rd_data == {key_y_ff, key_x_ff});

      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      key_x_in      = key_x_ff;
      key_y_in      = key_y_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_pos_in    = cmp_pos_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_pos_in    = res_pos_ff;

      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ring_off    = scan_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ring_addr;
      mem_wr_data = {coord_y[STORE_W-1:0], coord_x[STORE_W-1:0]};
      mem_rd_en   = 1'b0;
      mem_rd_addr = ring_addr;

      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            case (cmd)
               cdq_pkg::CMD_PUSH_BACK:  ring_off = count_ff;
               cdq_pkg::CMD_PUSH_FRONT: ring_off = CNT_W'(DEPTH - 1);
               cdq_pkg::CMD_POP_FRONT:  ring_off = CNT_W'(1);
               default:                 ring_off = count_ff;
            endcase
            if (req_valid) begin
               res_status_in = cdq_pkg::STATUS_DONE;
               res_found_in  = 1'b0;
               res_pos_in    = '0;
               state_in      = cdq_pkg::ST_RESULT;
               case (cmd)
                  cdq_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        res_status_in = cdq_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  cdq_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        res_status_in = cdq_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        head_in   = ring_addr;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  cdq_pkg::CMD_POP_FRONT: begin
                     if (empty) begin
                        res_status_in = cdq_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        head_in  = (count_ff == CNT_W'(1)) ? '0 : ring_addr;
                     end
                  end
                  cdq_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        res_status_in = cdq_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        if (count_ff == CNT_W'(1)) begin
                           head_in = '0;
                        end
                     end
                  end
                  cdq_pkg::CMD_SEARCH, cdq_pkg::CMD_SEARCH_SKIP: begin
                     key_x_in   = coord_x[STORE_W-1:0];
                     key_y_in   = coord_y[STORE_W-1:0];
                     scan_in    = (cmd == cdq_pkg::CMD_SEARCH_SKIP) ? CNT_W'(1) : '0;
                     cmp_vld_in = 1'b0;
                     state_in   = cdq_pkg::ST_SEARCH;
                  end
                  default: begin
                     res_status_in = cdq_pkg::STATUS_DONE;
                  end
               endcase
            end
         end
         cdq_pkg::ST_SEARCH: begin
            if (match) begin
               res_found_in = 1'b1;
               res_pos_in   = cmp_pos_ff;
               cmp_vld_in   = 1'b0;
               state_in     = cdq_pkg::ST_RESULT;
            end else if (scan_ff < count_ff) begin
               mem_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_pos_in = scan_ff;
               scan_in    = scan_ff + CNT_W'(1);
            end else begin
               cmp_vld_in = 1'b0;
               state_in   = cdq_pkg::ST_RESULT;
            end
         end
         cdq_pkg::ST_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = cdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase

      pos_wide     = WIDE_W'(res_pos_ff);
      len_wide     = WIDE_W'(count_ff);
      res.status   = res_status_ff;
      res.found    = res_found_ff;
      res.position = pos_wide[cdq_pkg::POS_W-1:0];
      res.length   = len_wide[cdq_pkg::LEN_W-1:0];
   end

   `CDQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "Entry count exceeds depth.")
   `CDQ_ASSERT_SAME(a_empty_head, clock, reset, count_ff == '0, head_ff == '0, "Empty queue with nonzero head.")
   `CDQ_ASSERT_SAME(a_cmp_in_range, clock, reset, (state_ff == cdq_pkg::ST_SEARCH) && cmp_vld_ff, cmp_pos_ff < count_ff, "Compared entry is not live.")
   `CDQ_ASSERT_NEXT(a_full_push, clock, reset, req_valid && req_ready && full && ((cmd == cdq_pkg::CMD_PUSH_BACK) || (cmd == cdq_pkg::CMD_PUSH_FRONT)), $stable(count_ff) && $stable(head_ff), "Refused push changed the queue.")
   `CDQ_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff != cdq_pkg::ST_IDLE, "Accepted transaction left the sequencer idle.")

endmodule

`default_nettype wire

FILE: src/coordinate_deque_with_search.sv
// Top level of the coordinate deque with search: stream ports, output register,
// and the sequencer with its coordinate store. Uses cdq_pkg, cdq_seq, cdq_ring_ram.
`default_nettype none

// A bounded double-ended queue of (x, y) coordinates held in a ring of DEPTH
// entries, with push and pop at either end and a search that reports whether
// and where a coordinate is stored, counted from the head. Each request
// transaction gives exactly one response transaction. A push, a pop or an unused
// command is carried out when it is accepted. A search compares the stored
// entries in turn, because the single read port of the coordinate store and
// the one comparator handle one entry per cycle, and it stops at the first
// match or after the last live entry. The block accepts no new request until
// the current one has finished and its response has moved into the output
// register. A response waiting there for rsp_tready holds back the following
// response, and with it any further request. The store needs no clearing
// after reset.
module coordinate_deque_with_search #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
   parameter int COORD_BITS = cdq_pkg::COORD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: coord_x[7:0], coord_y[15:8].
   input  wire logic [cdq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0: command[2:0].
   input  wire logic [cdq_pkg::CMD_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // Fields from bit 0: status[1:0], found[2], position[10:3], length[19:11],
   // zero padding[23:20].
   output logic      [cdq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int STORE_W = (COORD_BITS < cdq_pkg::COORD_W) ? COORD_BITS : cdq_pkg::COORD_W;
   localparam int IDX_W   = $clog2(DEPTH);

   logic                              res_valid;
   logic                              res_ready;
   cdq_pkg::res_type                  res;
   logic                              mem_wr_en;
   logic [IDX_W-1:0]                  mem_wr_addr;
   logic [2*STORE_W-1:0]              mem_wr_data;
   logic                              mem_rd_en;
   logic [IDX_W-1:0]                  mem_rd_addr;
   logic [2*STORE_W-1:0]              mem_rd_data;
   logic                              rsp_vld_ff, rsp_vld_in;
   logic [cdq_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   cdq_seq #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_BITS),
      .STORE_W    (STORE_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .cmd_bits    (req_tuser),
      .coord_x     (req_tdata[cdq_pkg::COORD_W-1:0]),
      .coord_y     (req_tdata[cdq_pkg::REQ_DATA_W-1:cdq_pkg::COORD_W]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   cdq_ring_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (2 * STORE_W)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      res_ready   = !rsp_vld_ff || rsp_tready;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = cdq_pkg::RSP_DATA_W'(res);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
